>>> design/srht_pkg.sv
// Shared types and constants for the segment/rectangle hit test pipeline.
// Depends on nothing; every other design file uses it.
package srht_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int CROSS_BITS = PROD_BITS + 1;

  // Rectangle corners, counterclockwise; side k runs from corner k to corner k+1.
  localparam int CORNER_LB = 0;
  localparam int CORNER_RB = 1;
  localparam int CORNER_RT = 2;
  localparam int CORNER_LT = 3;
  localparam int NUM_CORNERS = 4;

  localparam int SIDE_BOTTOM = 0;
  localparam int SIDE_RIGHT  = 1;
  localparam int SIDE_TOP    = 2;
  localparam int SIDE_LEFT   = 3;
  localparam int NUM_SIDES   = 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [CROSS_BITS-1:0] cross_t;

  // Ordered rectangle, segment endpoints, segment bounding box and direction.
  typedef struct packed {
    coord_t left;
    coord_t right;
    coord_t bottom;
    coord_t top;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    coord_t lo_x;
    coord_t hi_x;
    coord_t lo_y;
    coord_t hi_y;
    diff_t  dx;
    diff_t  dy;
  } order_t;

  typedef struct packed {
    logic                 box_ok;    // segment box overlaps the rectangle
    logic                 end_in;    // an endpoint lies in the rectangle
    logic [NUM_SIDES-1:0] side_box;  // segment box overlaps each side's box
  } flags_t;

  typedef struct packed {
    flags_t flags;
    diff_t  dx;
    diff_t  dy;
    diff_t  ux_l;  // left   - sx
    diff_t  ux_r;  // right  - sx
    diff_t  uy_b;  // bottom - sy
    diff_t  uy_t;  // top    - sy
  } offset_t;

  // Per corner: dx * (py - sy) and dy * (px - sx).
  typedef struct packed {
    flags_t                  flags;
    prod_t [NUM_CORNERS-1:0] pa;
    prod_t [NUM_CORNERS-1:0] pb;
  } cross_prod_t;

  // Exact difference of two coordinates, one bit wider.
  function automatic diff_t sub_c(coord_t a, coord_t b);
    return diff_t'({a[COORD_BITS-1], a}) - diff_t'({b[COORD_BITS-1], b});
  endfunction

endpackage

>>> design/srht_order.sv
// Stage 1: sort the corners into left/right/bottom/top, take the segment's
// bounding box and direction. Uses srht_pkg.
module srht_order (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  srht_pkg::coord_t    corner_a_x,
  input  srht_pkg::coord_t    corner_a_y,
  input  srht_pkg::coord_t    corner_b_x,
  input  srht_pkg::coord_t    corner_b_y,
  input  srht_pkg::coord_t    start_x,
  input  srht_pkg::coord_t    start_y,
  input  srht_pkg::coord_t    end_x,
  input  srht_pkg::coord_t    end_y,
  output logic                out_valid,
  input  logic                out_ready,
  output srht_pkg::order_t    out_data
);
  import srht_pkg::*;

  order_t data_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    data_next.left   = (corner_a_x < corner_b_x) ? corner_a_x : corner_b_x;
    data_next.right  = (corner_a_x < corner_b_x) ? corner_b_x : corner_a_x;
    data_next.bottom = (corner_a_y < corner_b_y) ? corner_a_y : corner_b_y;
    data_next.top    = (corner_a_y < corner_b_y) ? corner_b_y : corner_a_y;
    data_next.sx     = start_x;
    data_next.sy     = start_y;
    data_next.ex     = end_x;
    data_next.ey     = end_y;
    data_next.lo_x   = (start_x < end_x) ? start_x : end_x;
    data_next.hi_x   = (start_x < end_x) ? end_x : start_x;
    data_next.lo_y   = (start_y < end_y) ? start_y : end_y;
    data_next.hi_y   = (start_y < end_y) ? end_y : start_y;
    data_next.dx     = sub_c(end_x, start_x);
    data_next.dy     = sub_c(end_y, start_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

>>> design/srht_offset.sv
// Stage 2: overlap and containment flags, corner offsets from the start point.
// Uses srht_pkg.
module srht_offset (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  srht_pkg::order_t    in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output srht_pkg::offset_t   out_data
);
  import srht_pkg::*;

  offset_t data_next;
  logic    x_ovl;
  logic    y_ovl;
  logic    s_in;
  logic    e_in;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    x_ovl = (in_data.lo_x <= in_data.right) && (in_data.left <= in_data.hi_x);
    y_ovl = (in_data.lo_y <= in_data.top) && (in_data.bottom <= in_data.hi_y);
    s_in  = (in_data.sx >= in_data.left) && (in_data.sx <= in_data.right) &&
            (in_data.sy >= in_data.bottom) && (in_data.sy <= in_data.top);
    e_in  = (in_data.ex >= in_data.left) && (in_data.ex <= in_data.right) &&
            (in_data.ey >= in_data.bottom) && (in_data.ey <= in_data.top);

    data_next.flags.box_ok = x_ovl && y_ovl;
    data_next.flags.end_in = s_in || e_in;
    // A side is a flat box: the segment's span must straddle its fixed coordinate.
    // The orientation of the side's corners against the segment line is checked in srht_decide.
    data_next.flags.side_box[SIDE_BOTTOM] = x_ovl &&
      (in_data.lo_y <= in_data.bottom) && (in_data.bottom <= in_data.hi_y);
    data_next.flags.side_box[SIDE_TOP] = x_ovl &&
      (in_data.lo_y <= in_data.top) && (in_data.top <= in_data.hi_y);
    data_next.flags.side_box[SIDE_RIGHT] = y_ovl &&
      (in_data.lo_x <= in_data.right) && (in_data.right <= in_data.hi_x);
    data_next.flags.side_box[SIDE_LEFT] = y_ovl &&
      (in_data.lo_x <= in_data.left) && (in_data.left <= in_data.hi_x);

    data_next.dx   = in_data.dx;
    data_next.dy   = in_data.dy;
    data_next.ux_l = sub_c(in_data.left, in_data.sx);
    data_next.ux_r = sub_c(in_data.right, in_data.sx);
    data_next.uy_b = sub_c(in_data.bottom, in_data.sy);
    data_next.uy_t = sub_c(in_data.top, in_data.sy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

>>> design/srht_cross.sv
// Stage 3: the two products of the cross product for each rectangle corner.
// Uses srht_pkg.
module srht_cross (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  srht_pkg::offset_t     in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output srht_pkg::cross_prod_t out_data
);
  import srht_pkg::*;

  cross_prod_t data_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    data_next.flags = in_data.flags;
    data_next.pa[CORNER_LB] = in_data.dx * in_data.uy_b;
    data_next.pb[CORNER_LB] = in_data.dy * in_data.ux_l;
    data_next.pa[CORNER_RB] = in_data.dx * in_data.uy_b;
    data_next.pb[CORNER_RB] = in_data.dy * in_data.ux_r;
    data_next.pa[CORNER_RT] = in_data.dx * in_data.uy_t;
    data_next.pb[CORNER_RT] = in_data.dy * in_data.ux_r;
    data_next.pa[CORNER_LT] = in_data.dx * in_data.uy_t;
    data_next.pb[CORNER_LT] = in_data.dy * in_data.ux_l;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

>>> design/srht_decide.sv
// Stage 4: corner orientation signs, per-side verdicts, final hit register.
// Uses srht_pkg.
module srht_decide (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  srht_pkg::cross_prod_t in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  hit
);
  import srht_pkg::*;

  cross_t [NUM_CORNERS-1:0] cr;
  logic   [NUM_CORNERS-1:0] pos;
  logic   [NUM_CORNERS-1:0] neg;
  logic   [NUM_SIDES-1:0]   meet;
  logic                     hit_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    for (int k = 0; k < NUM_CORNERS; k++) begin
      cr[k]  = in_data.pa[k] - in_data.pb[k];
      neg[k] = cr[k][CROSS_BITS-1];
      pos[k] = !cr[k][CROSS_BITS-1] && (cr[k] != '0);
    end
    // Drop a side when both its corners lie strictly on one side of the segment line.
    meet[SIDE_BOTTOM] = in_data.flags.side_box[SIDE_BOTTOM] &&
      !((pos[CORNER_LB] && pos[CORNER_RB]) || (neg[CORNER_LB] && neg[CORNER_RB]));
    meet[SIDE_RIGHT] = in_data.flags.side_box[SIDE_RIGHT] &&
      !((pos[CORNER_RB] && pos[CORNER_RT]) || (neg[CORNER_RB] && neg[CORNER_RT]));
    meet[SIDE_TOP] = in_data.flags.side_box[SIDE_TOP] &&
      !((pos[CORNER_RT] && pos[CORNER_LT]) || (neg[CORNER_RT] && neg[CORNER_LT]));
    meet[SIDE_LEFT] = in_data.flags.side_box[SIDE_LEFT] &&
      !((pos[CORNER_LT] && pos[CORNER_LB]) || (neg[CORNER_LT] && neg[CORNER_LB]));
    hit_next = in_data.flags.box_ok && (in_data.flags.end_in || (|meet));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hit <= hit_next;
    end
  end

endmodule

>>> design/segment_rectangle_hit_test.sv
// Segment versus axis-aligned rectangle hit test, four register stages.
// Path: an accepted request is registered in srht_order, srht_offset, srht_cross and then
// srht_decide, whose register drives hit; the first stage loads at the accepting edge.
// Throughput: one request per cycle; each stage holds while the next one is full and stalled,
// and a stage with a bubble keeps filling, so a stall loses or repeats nothing.
// Reset (rst, synchronous) clears every stage's valid bit; data registers are not reset.
// Depends on srht_pkg, srht_order, srht_offset, srht_cross, srht_decide.
module segment_rectangle_hit_test (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  srht_pkg::coord_t corner_a_x,
  input  srht_pkg::coord_t corner_a_y,
  input  srht_pkg::coord_t corner_b_x,
  input  srht_pkg::coord_t corner_b_y,
  input  srht_pkg::coord_t start_x,
  input  srht_pkg::coord_t start_y,
  input  srht_pkg::coord_t end_x,
  input  srht_pkg::coord_t end_y,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             hit
);
  import srht_pkg::*;

  // Handshake between stages: each stage loads when it is empty or its
  // content moves on, so the ready chain runs back from the output.
  logic        s1_valid, s1_ready;
  logic        s2_valid, s2_ready;
  logic        s3_valid, s3_ready;
  order_t      s1_data;
  offset_t     s2_data;
  cross_prod_t s3_data;

  // Stage 1: order the corners, segment box and direction.
  srht_order u_order (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .corner_a_x (corner_a_x),
    .corner_a_y (corner_a_y),
    .corner_b_x (corner_b_x),
    .corner_b_y (corner_b_y),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .out_valid  (s1_valid),
    .out_ready  (s1_ready),
    .out_data   (s1_data)
  );

  // Stage 2: box overlap, endpoint containment, corner offsets.
  srht_offset u_offset (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  // Stage 3: eight signed multiplies, two per corner.
  srht_cross u_cross (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_data   (s2_data),
    .out_valid (s3_valid),
    .out_ready (s3_ready),
    .out_data  (s3_data)
  );

  // Stage 4: subtract, take signs, combine per side; this is the output register.
  srht_decide u_decide (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_valid),
    .in_ready  (s3_ready),
    .in_data   (s3_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit)
  );

endmodule

>>> design/srht_checker.sv
// Port-level checks for segment_rectangle_hit_test, attached by bind.
// Uses srht_pkg for the coordinate type.
module srht_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input srht_pkg::coord_t corner_a_x,
  input srht_pkg::coord_t corner_a_y,
  input srht_pkg::coord_t corner_b_x,
  input srht_pkg::coord_t corner_b_y,
  input srht_pkg::coord_t start_x,
  input srht_pkg::coord_t start_y,
  input srht_pkg::coord_t end_x,
  input srht_pkg::coord_t end_y,
  input logic             out_valid,
  input logic             out_ready,
  input logic             hit
);

  // Reset empties the output stage.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit))
    else $error("stalled result changed");

  // Start point on a rectangle corner is a hit, checked when the output is never stalled.
  a_corner_hit: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && start_x == corner_a_x && start_y == corner_a_y
    ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid && hit)
    else $error("endpoint on corner not reported as hit");

  // Segment entirely right of the rectangle is a miss.
  a_right_miss: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && start_x > corner_a_x && start_x > corner_b_x &&
    end_x > corner_a_x && end_x > corner_b_x
    ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid && !hit)
    else $error("segment right of rectangle reported as hit");

endmodule

bind segment_rectangle_hit_test srht_checker u_srht_checker (.*);
